// ===== sv/qnorm_pkg.sv =====
// qnorm_pkg: shared constants and types for the quaternion normaliser
// no dependencies
package qnorm_pkg;

    localparam int IN_FRAC_BITS_DEF  = 12;
    localparam int OUT_FRAC_BITS_DEF = 14;
    localparam int COMP_W            = 16;
    localparam int SUM_W             = 34;
    localparam int ROOT_W            = 17;
    localparam int ROOT_STEPS        = 17;
    localparam logic [15:0] MIN_NORM_RST = 16'd1;

    // one step of the restoring square root
    typedef struct packed {
        logic [SUM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_state_t;

endpackage

// ===== sv/qnorm_sqrt_cell.sv =====
// qnorm_sqrt_cell: one stage of the pipelined integer square root
// depends on qnorm_pkg
module qnorm_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  qnorm_pkg::sqrt_state_t in_st,
    input  logic [63:0]            in_comps,
    input  logic [15:0]            in_min,
    output logic                   out_valid,
    output qnorm_pkg::sqrt_state_t out_st,
    output logic [63:0]            out_comps,
    output logic [15:0]            out_min
);
    import qnorm_pkg::*;

    localparam int SH = 2 * (ROOT_STEPS - 1 - STEP);

    logic [SUM_W+1:0]  trial;
    logic [SUM_W+1:0]  rem_sh;
    sqrt_state_t       st_next;
    logic              valid_reg;
    sqrt_state_t       st_reg;
    logic [63:0]       comps_reg;
    logic [15:0]       min_reg;

    // compare remainder top bits against 4*root+1
    always_comb
    begin
        rem_sh  = {2'b00, in_st.rem} >> SH;
        trial   = {{(SUM_W-ROOT_W){1'b0}}, in_st.root, 2'b01};
        st_next = in_st;
        if (rem_sh >= trial)
        begin
            st_next.rem  = in_st.rem - SUM_W'(trial << SH);
            st_next.root = {in_st.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            st_next.root = {in_st.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        st_reg    <= st_next;
        comps_reg <= in_comps;
        min_reg   <= in_min;
    end

    assign out_valid = valid_reg;
    assign out_st    = st_reg;
    assign out_comps = comps_reg;
    assign out_min   = min_reg;
endmodule

// ===== sv/qnorm_div_cell.sv =====
// qnorm_div_cell: one restoring division stage for four components at once
// depends on qnorm_pkg
module qnorm_div_cell #(
    parameter int NUM_W = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [4*NUM_W-1:0]       in_num,
    input  logic [4*(qnorm_pkg::ROOT_W+1)-1:0] in_rem,
    input  logic [4*NUM_W-1:0]       in_quo,
    input  logic [qnorm_pkg::ROOT_W-1:0] in_den,
    input  logic [4:0]               in_side,
    output logic                     out_valid,
    output logic [4*NUM_W-1:0]       out_num,
    output logic [4*(qnorm_pkg::ROOT_W+1)-1:0] out_rem,
    output logic [4*NUM_W-1:0]       out_quo,
    output logic [qnorm_pkg::ROOT_W-1:0] out_den,
    output logic [4:0]               out_side
);
    import qnorm_pkg::*;

    localparam int RW = ROOT_W + 1;

    logic [4*NUM_W-1:0] num_next;
    logic [4*RW-1:0]    rem_next;
    logic [4*NUM_W-1:0] quo_next;
    logic [RW:0]        sh;
    logic               valid_reg;
    logic [4*NUM_W-1:0] num_reg;
    logic [4*RW-1:0]    rem_reg;
    logic [4*NUM_W-1:0] quo_reg;
    logic [ROOT_W-1:0]  den_reg;
    logic [4:0]         side_reg;

    // shift in next numerator bit, subtract when it fits
    always_comb
    begin
        num_next = '0;
        rem_next = '0;
        quo_next = '0;
        sh       = '0;
        for (int i = 0; i < 4; i++)
        begin
            sh = {in_rem[i*RW +: RW], in_num[i*NUM_W + NUM_W-1]};
            num_next[i*NUM_W +: NUM_W] = {in_num[i*NUM_W +: NUM_W-1], 1'b0};
            if (sh >= {2'b00, in_den})
            begin
                rem_next[i*RW +: RW] = RW'(sh - {2'b00, in_den});
                quo_next[i*NUM_W +: NUM_W] = {in_quo[i*NUM_W +: NUM_W-1], 1'b1};
            end
            else
            begin
                rem_next[i*RW +: RW] = RW'(sh);
                quo_next[i*NUM_W +: NUM_W] = {in_quo[i*NUM_W +: NUM_W-1], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        den_reg  <= in_den;
        side_reg <= in_side;
    end

    assign out_valid = valid_reg;
    assign out_num   = num_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;
    assign out_den   = den_reg;
    assign out_side  = side_reg;
endmodule

// ===== sv/quaternion_normalize.sv =====
// quaternion_normalize: streaming quaternion normaliser, top level
// depends on qnorm_pkg, qnorm_sqrt_cell, qnorm_div_cell
//
// usage: drive comp_w..comp_z and pulse start; busy is always low, so a
// transaction is taken on every cycle that start is high, one per cycle.
// each transaction gives exactly one result, shown for one cycle with
// done high on unit_w..unit_z and norm_too_small.
// from start to done the pipeline is a squares stage, a chain of 17
// square-root cells and a chain of NUM_W division cells, one bit each,
// then a saturation stage. throughput is one transaction per cycle.
// results are only produced on done; the receiver cannot stall, and none
// is needed since the pipeline never backs up.
// min_norm is written through cfg_valid/cfg_ready (cfg_ready is always
// high); write it only while no transaction is in flight.
// the input fraction bits cancel in the quotient and set no logic here.
// reset clears all valid flags and sets min_norm to 1.
module quaternion_normalize #(
    parameter int OUT_FRAC_BITS = qnorm_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic signed [15:0] comp_w,
    input  logic signed [15:0] comp_x,
    input  logic signed [15:0] comp_y,
    input  logic signed [15:0] comp_z,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output logic        done,
    output logic signed [15:0] unit_w,
    output logic signed [15:0] unit_x,
    output logic signed [15:0] unit_y,
    output logic signed [15:0] unit_z,
    output logic        norm_too_small
);
    import qnorm_pkg::*;

    // numerator |c| << OUT_FRAC_BITS plus half the norm
    localparam int NUM_W = COMP_W + OUT_FRAC_BITS + 1;
    localparam int RW    = ROOT_W + 1;

    logic [15:0] min_norm_reg;
    logic        sq_valid_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [63:0] sq_comps_reg;
    logic [15:0] sq_min_reg;
    logic [31:0] sq_p [4];
    logic [15:0] mag [4];

    // configuration register
    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_norm_reg <= MIN_NORM_RST;
        else if (cfg_valid && cfg_ready)
            min_norm_reg <= cfg_data;
    end

    // squares and sum
    always_comb
    begin
        mag[0] = comp_w[15] ? 16'(-comp_w) : comp_w;
        mag[1] = comp_x[15] ? 16'(-comp_x) : comp_x;
        mag[2] = comp_y[15] ? 16'(-comp_y) : comp_y;
        mag[3] = comp_z[15] ? 16'(-comp_z) : comp_z;
        for (int i = 0; i < 4; i++)
            sq_p[i] = mag[i] * mag[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_valid_reg <= 1'b0;
        else
            sq_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= SUM_W'(sq_p[0]) + SUM_W'(sq_p[1]) + SUM_W'(sq_p[2]) + SUM_W'(sq_p[3]);
        sq_comps_reg <= {comp_w, comp_x, comp_y, comp_z};
        sq_min_reg   <= min_norm_reg;
    end

    // square root chain
    logic        s_valid [ROOT_STEPS+1];
    sqrt_state_t s_st    [ROOT_STEPS+1];
    logic [63:0] s_comps [ROOT_STEPS+1];
    logic [15:0] s_min   [ROOT_STEPS+1];

    assign s_valid[0]    = sq_valid_reg;
    assign s_st[0]       = {sum_reg, {ROOT_W{1'b0}}};
    assign s_comps[0]    = sq_comps_reg;
    assign s_min[0]      = sq_min_reg;

    for (genvar k = 0; k < ROOT_STEPS; k++)
    begin : g_sqrt
        qnorm_sqrt_cell #(.STEP(k)) u_cell (
            .clk(clk), .rst_n(rst_n),
            .in_valid(s_valid[k]), .in_st(s_st[k]),
            .in_comps(s_comps[k]), .in_min(s_min[k]),
            .out_valid(s_valid[k+1]), .out_st(s_st[k+1]),
            .out_comps(s_comps[k+1]), .out_min(s_min[k+1])
        );
    end

    // divider set-up: flag, signs and numerators
    logic [ROOT_W-1:0] norm;
    logic              too_small;
    logic [4*NUM_W-1:0] num0;
    logic [4:0]        side0;
    logic [15:0]       cm [4];

    always_comb
    begin
        norm      = s_st[ROOT_STEPS].root;
        too_small = (norm == '0) || (norm < {1'b0, s_min[ROOT_STEPS]});
        num0      = '0;
        for (int i = 0; i < 4; i++)
        begin
            cm[i] = s_comps[ROOT_STEPS][(3-i)*16 +: 16];
            side0[i] = cm[i][15];
            num0[i*NUM_W +: NUM_W] = (NUM_W'(cm[i][15] ? 16'(-cm[i]) : cm[i])
                                      << OUT_FRAC_BITS) + NUM_W'(norm >> 1);
        end
        side0[4] = too_small;
    end

    // division chain
    logic               d_valid [NUM_W+1];
    logic [4*NUM_W-1:0] d_num   [NUM_W+1];
    logic [4*RW-1:0]    d_rem   [NUM_W+1];
    logic [4*NUM_W-1:0] d_quo   [NUM_W+1];
    logic [ROOT_W-1:0]  d_den   [NUM_W+1];
    logic [4:0]         d_side  [NUM_W+1];

    assign d_valid[0] = s_valid[ROOT_STEPS];
    assign d_num[0]   = num0;
    assign d_rem[0]   = '0;
    assign d_quo[0]   = '0;
    assign d_den[0]   = norm;
    assign d_side[0]  = side0;

    for (genvar k = 0; k < NUM_W; k++)
    begin : g_div
        qnorm_div_cell #(.NUM_W(NUM_W)) u_cell (
            .clk(clk), .rst_n(rst_n),
            .in_valid(d_valid[k]), .in_num(d_num[k]), .in_rem(d_rem[k]),
            .in_quo(d_quo[k]), .in_den(d_den[k]), .in_side(d_side[k]),
            .out_valid(d_valid[k+1]), .out_num(d_num[k+1]), .out_rem(d_rem[k+1]),
            .out_quo(d_quo[k+1]), .out_den(d_den[k+1]), .out_side(d_side[k+1])
        );
    end

    // saturate, apply sign, zero when the norm is too small, output register
    logic              done_reg;
    logic [15:0]       unit_reg [4];
    logic              small_reg;
    logic [15:0]       unit_next [4];
    logic [NUM_W-1:0]  q;
    logic [NUM_W-1:0]  one;

    always_comb
    begin
        one = NUM_W'(1) << OUT_FRAC_BITS;
        q   = '0;
        for (int i = 0; i < 4; i++)
        begin
            q = d_quo[NUM_W][i*NUM_W +: NUM_W];
            if (q > one)
                q = one;
            if (d_side[NUM_W][i])
                q = NUM_W'(-q);
            unit_next[i] = d_side[NUM_W][4] ? 16'd0 : q[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= d_valid[NUM_W];
    end

    always_ff @(posedge clk)
    begin
        unit_reg  <= unit_next;
        small_reg <= d_side[NUM_W][4];
    end

    assign done           = done_reg;
    assign unit_w         = unit_reg[0];
    assign unit_x         = unit_reg[1];
    assign unit_y         = unit_reg[2];
    assign unit_z         = unit_reg[3];
    assign norm_too_small = small_reg;
endmodule
